// File: design/sjv_pkg.sv
// Shared types and codes of the strict JSON object validator.
`timescale 1ns / 1ps
`default_nettype none
package sjv_pkg;

	// Default number of nesting stack entries.
	localparam int StackEntriesDef = 256;
	// Reset value of the nesting limit register.
	localparam logic [7:0] MaxNestingRst = 8'd128;

	// Status codes carried on the result.
	typedef enum logic [3:0] {
		STS_RUN      = 4'd0,
		STS_OK       = 4'd1,
		STS_NEST     = 4'd2,
		STS_NOT_OBJ  = 4'd3,
		STS_KEY      = 4'd4,
		STS_COLON    = 4'd5,
		STS_VALUE    = 4'd6,
		STS_LITERAL  = 4'd7,
		STS_NUMBER   = 4'd8,
		STS_COMMA    = 4'd9,
		STS_STRING   = 4'd10,
		STS_TRAILING = 4'd11,
		STS_UNTERM   = 4'd12
	} status_t;

	// One classified byte as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ws;
		logic       digit;
		logic       hex_ok;
		logic [3:0] hex_val;
	} cls_t;

endpackage
`default_nettype wire

// File: design/sjv_front.sv
// Front end: accepts bytes and classifies them into the queue.
`timescale 1ns / 1ps
`default_nettype none
module sjv_front import sjv_pkg::*; (
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       q_full,
	output logic            q_push,
	output cls_t            q_data
);

	// The queue takes a request whenever it has room.
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Character classes used by the scanner.
	always_comb begin
		q_data.data   = data_byte;
		q_data.last   = last_byte;
		q_data.ws     = (data_byte == 8'h20) || (data_byte == 8'h09) ||
		                (data_byte == 8'h0A) || (data_byte == 8'h0D);
		q_data.digit  = (data_byte >= "0") && (data_byte <= "9");
		q_data.hex_ok = 1'b1;
		q_data.hex_val = 4'd0;
		if (q_data.digit) begin
			q_data.hex_val = 4'(data_byte - "0");
		end else if ((data_byte >= "a") && (data_byte <= "f")) begin
			q_data.hex_val = 4'(data_byte - "a" + 8'd10);
		end else if ((data_byte >= "A") && (data_byte <= "F")) begin
			q_data.hex_val = 4'(data_byte - "A" + 8'd10);
		end else begin
			q_data.hex_ok = 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: design/sjv_queue.sv
// Short queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module sjv_queue import sjv_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cls_t push_data,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output cls_t      head
);

	localparam int Depth = 4;
	localparam int PW    = $clog2(Depth);

	cls_t          mem_q [Depth];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;

	assign full      = (cnt_q == (PW+1)'(Depth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: design/sjv_back.sv
// Back end: syntax scanner, nesting stack and result register.
`timescale 1ns / 1ps
`default_nettype none
module sjv_back import sjv_pkg::*; #(
	parameter int STACK_ENTRIES = StackEntriesDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] max_nesting_q,
	input  wire logic       q_not_empty,
	input  wire cls_t       q_head,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [3:0]      status,
	output logic [8:0]      nest_level
);

	localparam int LW = $clog2(STACK_ENTRIES + 1);
	localparam int AW = $clog2(STACK_ENTRIES);

	typedef enum logic [4:0] {
		S_TOP = 5'd0, S_OBJ_FIRST = 5'd1, S_OBJ_KEY = 5'd2, S_COLON = 5'd3,
		S_VALUE = 5'd4, S_ARR_FIRST = 5'd5, S_AFTER = 5'd6, S_DONE = 5'd7,
		S_LIT_T = 5'd8, S_LIT_F = 5'd9, S_LIT_N = 5'd10,
		S_N_SIGN = 5'd11, S_N_ZERO = 5'd12, S_N_INT = 5'd13, S_N_DOT = 5'd14,
		S_N_FRAC = 5'd15, S_N_EXP = 5'd16, S_N_EXPSIGN = 5'd17, S_N_EXPD = 5'd18,
		S_K_BODY = 5'd19, S_K_ESC = 5'd20, S_K_HEX = 5'd21, S_K_BS = 5'd22,
		S_K_U = 5'd23,
		S_V_BODY = 5'd24, S_V_ESC = 5'd25, S_V_HEX = 5'd26, S_V_BS = 5'd27,
		S_V_U = 5'd28
	} scan_t;

	// Literal spelling, indexed by literal kind and position.
	function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
		logic [7:0] c;
		c = 8'h00;
		unique case (k)
			2'd0: begin
				unique case (p)
					3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
					default: c = 8'h00;
				endcase
			end
			2'd1: begin
				unique case (p)
					3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
					3'd4: c = "e";
					default: c = 8'h00;
				endcase
			end
			2'd2: begin
				unique case (p)
					3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Verdict when the final byte arrives without an earlier error.
	function automatic logic [3:0] verdict(input scan_t s, input logic top_obj);
		logic [3:0] v;
		if (s >= S_V_BODY)     v = STS_STRING;
		else if (s >= S_K_BODY) v = STS_KEY;
		else if (s >= S_LIT_T && s <= S_LIT_N) v = STS_LITERAL;
		else begin
			unique case (s)
				S_DONE: v = STS_OK;
				S_OBJ_FIRST, S_OBJ_KEY, S_ARR_FIRST: v = STS_UNTERM;
				S_COLON: v = STS_COLON;
				S_VALUE: v = top_obj ? STS_VALUE : STS_UNTERM;
				S_AFTER, S_N_ZERO, S_N_INT, S_N_FRAC, S_N_EXPD: v = STS_COMMA;
				S_N_SIGN, S_N_DOT, S_N_EXP, S_N_EXPSIGN: v = STS_NUMBER;
				default: v = STS_NOT_OBJ;
			endcase
		end
		return v;
	endfunction

	logic          kind_mem [STACK_ENTRIES];
	scan_t         st_q, st_d;
	logic [LW-1:0] lvl_q, lvl_d;
	logic [2:0]    lit_q, lit_d;
	logic [2:0]    hcnt_q, hcnt_d;
	logic [15:0]   hacc_q, hacc_d;
	logic          hs_q, hs_d;
	logic [3:0]    err_q, err_d;
	logic          top_q, top_d;
	logic          below_q;
	logic          fire;
	logic          push, want_open, open_obj, want_close, do_after;
	logic [3:0]    fcode;
	logic          topobj;
	logic [7:0]    b;
	logic [15:0]   acc_n;
	logic [2:0]    cnt_n;
	logic          str_val;
	scan_t         base;
	logic [3:0]    scode;
	logic [3:0]    sts_d;
	logic [LW-1:0] rd_lvl;

	assign fire   = q_not_empty && (!out_valid || out_ready);
	assign q_pop  = fire;
	assign b      = q_head.data;
	assign topobj = (lvl_q == '0) || top_q;

	// Scanner next state for one byte.
	always_comb begin
		st_d = st_q; lvl_d = lvl_q; lit_d = lit_q; hcnt_d = hcnt_q;
		hacc_d = hacc_q; hs_d = hs_q; top_d = top_q;
		fcode = STS_RUN; want_open = 1'b0; open_obj = 1'b0;
		want_close = 1'b0; do_after = 1'b0; push = 1'b0;
		acc_n = {hacc_q[11:0], q_head.hex_val};
		cnt_n = hcnt_q + 3'd1;
		str_val = (st_q >= S_V_BODY);
		base  = str_val ? S_V_BODY : S_K_BODY;
		scode = str_val ? STS_STRING : STS_KEY;
		if (err_q == STS_RUN) begin
			if (st_q >= S_K_BODY) begin
				// String body, escapes and unicode escapes.
				unique case (5'(st_q - base))
					5'd0: begin
						if (b == "\"") st_d = str_val ? S_AFTER : S_COLON;
						else if (b < 8'h20) fcode = scode;
						else if (b == "\\") st_d = scan_t'(base + 5'd1);
					end
					5'd1: begin
						if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
						    b == "n" || b == "r" || b == "t") st_d = base;
						else if (b == "u") begin
							st_d = scan_t'(base + 5'd2); hcnt_d = '0; hacc_d = '0;
						end else fcode = scode;
					end
					5'd2: begin
						if (!q_head.hex_ok) fcode = scode;
						else begin
							hacc_d = acc_n;
							hcnt_d = cnt_n;
							if (cnt_n == 3'd4) begin
								hcnt_d = '0;
								if (hs_q) begin
									hs_d = 1'b0;
									if (acc_n < 16'hDC00 || acc_n > 16'hDFFF) fcode = scode;
									else st_d = base;
								end else if (acc_n >= 16'hD800 && acc_n <= 16'hDBFF) begin
									hs_d = 1'b1;
									st_d = scan_t'(base + 5'd3);
								end else if (acc_n >= 16'hDC00 && acc_n <= 16'hDFFF) begin
									fcode = scode;
								end else st_d = base;
							end
						end
					end
					5'd3: begin
						if (b == "\\") st_d = scan_t'(base + 5'd4); else fcode = scode;
					end
					default: begin
						if (b == "u") begin
							st_d = scan_t'(base + 5'd2); hcnt_d = '0; hacc_d = '0;
						end else fcode = scode;
					end
				endcase
			end else if (st_q >= S_LIT_T && st_q <= S_LIT_N) begin
				// Literal spelling check.
				if (b != lit_char(2'(st_q - S_LIT_T), lit_q) ||
				    (st_q != S_LIT_F && lit_q >= 3'd4)) fcode = STS_LITERAL;
				else begin
					lit_d = lit_q + 3'd1;
					if ((st_q == S_LIT_F && lit_q == 3'd4) ||
					    (st_q != S_LIT_F && lit_q == 3'd3)) begin
						lit_d = '0; st_d = S_AFTER;
					end
				end
			end else begin
				unique case (st_q)
					S_TOP: begin
						if (!q_head.ws) begin
							if (b == "{") begin want_open = 1'b1; open_obj = 1'b1; end
							else fcode = STS_NOT_OBJ;
						end
					end
					S_OBJ_FIRST, S_OBJ_KEY: begin
						if (!q_head.ws) begin
							if (b == "}" && st_q == S_OBJ_FIRST) want_close = 1'b1;
							else if (b == "\"") st_d = S_K_BODY;
							else fcode = STS_KEY;
						end
					end
					S_COLON: begin
						if (!q_head.ws) begin
							if (b == ":") st_d = S_VALUE; else fcode = STS_COLON;
						end
					end
					S_VALUE, S_ARR_FIRST: begin
						if (!q_head.ws) begin
							if (b == "]" && st_q == S_ARR_FIRST) want_close = 1'b1;
							else if (b == "{") begin want_open = 1'b1; open_obj = 1'b1; end
							else if (b == "[") want_open = 1'b1;
							else if (b == "\"") st_d = S_V_BODY;
							else if (b == "t") begin st_d = S_LIT_T; lit_d = 3'd1; end
							else if (b == "f") begin st_d = S_LIT_F; lit_d = 3'd1; end
							else if (b == "n") begin st_d = S_LIT_N; lit_d = 3'd1; end
							else if (b == "-") st_d = S_N_SIGN;
							else if (b == "0") st_d = S_N_ZERO;
							else if (q_head.digit) st_d = S_N_INT;
							else fcode = STS_NUMBER;
						end
					end
					S_AFTER: do_after = 1'b1;
					S_DONE: if (!q_head.ws) fcode = STS_TRAILING;
					S_N_SIGN: begin
						if (b == "0") st_d = S_N_ZERO;
						else if (q_head.digit) st_d = S_N_INT;
						else fcode = STS_NUMBER;
					end
					S_N_ZERO, S_N_INT: begin
						if (q_head.digit) begin
							if (st_q == S_N_ZERO) fcode = STS_NUMBER;
						end else if (b == ".") st_d = S_N_DOT;
						else if (b == "e" || b == "E") st_d = S_N_EXP;
						else do_after = 1'b1;
					end
					S_N_DOT: if (q_head.digit) st_d = S_N_FRAC; else fcode = STS_NUMBER;
					S_N_FRAC: begin
						if (!q_head.digit) begin
							if (b == "e" || b == "E") st_d = S_N_EXP; else do_after = 1'b1;
						end
					end
					S_N_EXP: begin
						if (b == "+" || b == "-") st_d = S_N_EXPSIGN;
						else if (q_head.digit) st_d = S_N_EXPD;
						else fcode = STS_NUMBER;
					end
					S_N_EXPSIGN: if (q_head.digit) st_d = S_N_EXPD; else fcode = STS_NUMBER;
					S_N_EXPD: if (!q_head.digit) do_after = 1'b1;
					default: fcode = STS_NOT_OBJ;
				endcase
			end
			// Separator or close after a complete value.
			if (do_after) begin
				st_d = S_AFTER;
				if (!q_head.ws) begin
					if ((topobj && b == "}") || (!topobj && b == "]")) want_close = 1'b1;
					else if (b == ",") st_d = topobj ? S_OBJ_KEY : S_VALUE;
					else fcode = STS_COMMA;
				end
			end
			// Push a new level, checked against the limit and the stack size.
			if (want_open) begin
				if (32'(lvl_q) > 32'(max_nesting_q) || 32'(lvl_q) >= 32'(STACK_ENTRIES))
					fcode = STS_NEST;
				else begin
					push = 1'b1;
					lvl_d = lvl_q + 1'b1;
					top_d = open_obj;
					st_d = open_obj ? S_OBJ_FIRST : S_ARR_FIRST;
				end
			end
			// Pop a level; the kind below comes from the prefetch register.
			if (want_close) begin
				if (lvl_q != '0) lvl_d = lvl_q - 1'b1;
				top_d = below_q;
				st_d = (lvl_d == '0) ? S_DONE : S_AFTER;
			end
		end
		err_d = (err_q != STS_RUN) ? err_q : fcode;
		sts_d = err_d;
		if (q_head.last && err_d == STS_RUN)
			sts_d = verdict(st_d, (lvl_d == '0) || top_d);
		rd_lvl = lvl_d - LW'(2);
	end

	// Stack memory with a registered read of the entry under the top.
	always_ff @(posedge clk) begin
		if (fire) begin
			if (push) kind_mem[lvl_q[AW-1:0]] <= open_obj;
			below_q <= kind_mem[rd_lvl[AW-1:0]];
		end
	end

	// Scanner state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_TOP; lvl_q <= '0; lit_q <= '0; hcnt_q <= '0;
			hacc_q <= '0; hs_q <= 1'b0; err_q <= STS_RUN; top_q <= 1'b0;
			out_valid <= 1'b0; status <= STS_RUN; nest_level <= '0;
		end else begin
			out_valid <= fire || (out_valid && !out_ready);
			if (fire) begin
				status     <= sts_d;
				nest_level <= 9'(lvl_d);
				if (q_head.last) begin
					st_q <= S_TOP; lvl_q <= '0; lit_q <= '0; hcnt_q <= '0;
					hacc_q <= '0; hs_q <= 1'b0; err_q <= STS_RUN; top_q <= 1'b0;
				end else begin
					st_q <= st_d; lvl_q <= lvl_d; lit_q <= lit_d; hcnt_q <= hcnt_d;
					hacc_q <= hacc_d; hs_q <= hs_d; err_q <= err_d; top_q <= top_d;
				end
			end
		end
	end

	// The open level count never passes the stack size.
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(lvl_q) <= 32'(STACK_ENTRIES))
		else $error("nesting level beyond stack size");

	// An error holds until the final byte.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && err_q != STS_RUN && !q_head.last) |=> (err_q == $past(err_q)))
		else $error("error code changed before the final byte");

	// The final byte returns the scanner to its reset state.
	a_end_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && q_head.last) |=> (lvl_q == '0 && err_q == STS_RUN && st_q == S_TOP))
		else $error("scanner not cleared after final byte");

endmodule
`default_nettype wire

// File: design/strict_json_object_validator.sv
// Top level of the strict JSON object validator.
// Each accepted byte request yields one result (status and nest_level), loaded into the
// result register when the byte leaves the queue; a new byte may be accepted every cycle
// while the queue has room, and a four-entry queue separates the byte input from the
// result register so either side can stall. The user must write the nesting limit through
// the cfg port only while no document is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module strict_json_object_validator import sjv_pkg::*; #(
	parameter int STACK_ENTRIES = StackEntriesDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] max_nesting,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [3:0]      status,
	output logic [8:0]      nest_level
);

	logic [7:0] max_nesting_q;
	logic       q_full, q_push, q_pop, q_not_empty;
	cls_t       q_in, q_head;

	// Nesting limit register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_nesting_q <= MaxNestingRst;
		end else if (cfg_valid) begin
			max_nesting_q <= max_nesting;
		end
	end

	sjv_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_in)
	);

	sjv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	sjv_back #(.STACK_ENTRIES(STACK_ENTRIES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_nesting_q(max_nesting_q),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.nest_level   (nest_level)
	);

endmodule
`default_nettype wire

// File: dv/tb_strict_json_object_validator.sv
// Self-checking testbench of the strict JSON object validator.
`timescale 1ns / 1ps
module tb_strict_json_object_validator;
	import sjv_pkg::*;

	// Scan positions of the validator, mirrored from its behavior.
	localparam int unsigned SC_TOP = 0, SC_OBJ_FIRST = 1, SC_OBJ_KEY = 2, SC_COLON = 3;
	localparam int unsigned SC_VALUE = 4, SC_ARR_FIRST = 5, SC_AFTER = 6, SC_DONE = 7;
	localparam int unsigned SC_LIT = 8, SC_NUM_SIGN = 11, SC_NUM_ZERO = 12, SC_NUM_INT = 13;
	localparam int unsigned SC_NUM_DOT = 14, SC_NUM_FRAC = 15, SC_NUM_EXP = 16;
	localparam int unsigned SC_NUM_EXPSIGN = 17, SC_NUM_EXPDIG = 18;
	localparam int unsigned SC_KEY_STR = 19, SC_VAL_STR = 24;
	localparam int unsigned STR_BODY = 0, STR_ESC = 1, STR_HEX = 2, STR_BSLASH = 3, STR_U = 4;
	localparam int unsigned DEPTH = StackEntriesDef;

	typedef struct {
		logic [7:0] b;
		logic       last;
	} text_byte_t;

	typedef struct {
		status_t    sts;
		logic [8:0] lvl;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] max_nesting = 8'd0;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic [3:0] status;
	logic [8:0] nest_level;

	strict_json_object_validator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_nesting(max_nesting),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .nest_level(nest_level)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	text_byte_t  pend_q[$];
	verdict_t    verdict_q[$];
	logic [7:0]  doc[$];
	int          n_fail = 0, n_docs = 0, n_bytes = 0, n_ok = 0, n_err = 0, n_results = 0;
	bit          steady = 1'b0, hold = 1'b0;

	// Predictor state.
	bit          kind_stk[DEPTH];
	int unsigned lvl, sc, litpos, hexcnt;
	logic [15:0] hexacc;
	bit          hisur;
	status_t     sc_err;
	logic [7:0]  lim;

	function automatic bit is_ws(logic [7:0] b);
		return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
	endfunction

	function automatic bit is_dig(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [7:0] lit_char(int unsigned k, int unsigned p);
		string t;
		t = (k == 0) ? "true" : (k == 1) ? "false" : "null";
		return (p < t.len()) ? t[p] : 8'h00;
	endfunction

	task automatic clear_scan();
		foreach (kind_stk[i]) kind_stk[i] = 1'b0;
		lvl = 0; sc = SC_TOP; litpos = 0; hexcnt = 0; hexacc = '0; hisur = 1'b0;
		sc_err = STS_RUN;
	endtask

	task automatic set_err(status_t c);
		if (sc_err == STS_RUN) sc_err = c;
	endtask

	function automatic bit top_obj();
		return (lvl == 0) ? 1'b1 : kind_stk[lvl - 1];
	endfunction

	task automatic open_lvl(bit obj);
		if (lvl > lim || lvl >= DEPTH) begin
			set_err(STS_NEST);
		end else begin
			kind_stk[lvl] = obj;
			lvl++;
			sc = obj ? SC_OBJ_FIRST : SC_ARR_FIRST;
		end
	endtask

	task automatic close_lvl();
		if (lvl > 0) lvl--;
		sc = (lvl == 0) ? SC_DONE : SC_AFTER;
	endtask

	task automatic start_value(logic [7:0] b);
		if (b == "{") open_lvl(1'b1);
		else if (b == "[") open_lvl(1'b0);
		else if (b == "\"") sc = SC_VAL_STR + STR_BODY;
		else if (b == "t") begin sc = SC_LIT; litpos = 1; end
		else if (b == "f") begin sc = SC_LIT + 1; litpos = 1; end
		else if (b == "n") begin sc = SC_LIT + 2; litpos = 1; end
		else if (b == "-") sc = SC_NUM_SIGN;
		else if (b == "0") sc = SC_NUM_ZERO;
		else if (b >= "1" && b <= "9") sc = SC_NUM_INT;
		else set_err(STS_NUMBER);
	endtask

	task automatic finish_value(logic [7:0] b);
		sc = SC_AFTER;
		if (!is_ws(b)) begin
			if (b == (top_obj() ? "}" : "]")) close_lvl();
			else if (b == ",") sc = top_obj() ? SC_OBJ_KEY : SC_VALUE;
			else set_err(STS_COMMA);
		end
	endtask

	// One byte inside a key or value string, including escapes and surrogates.
	task automatic string_step(int unsigned base, logic [7:0] b, status_t code,
			int unsigned done_sc);
		int unsigned sub;
		int          h;
		sub = sc - base;
		h = (b >= "0" && b <= "9") ? b - "0" : (b >= "a" && b <= "f") ? b - "a" + 10 :
			(b >= "A" && b <= "F") ? b - "A" + 10 : 16;
		case (sub)
			STR_BODY: begin
				if (b == "\"") sc = done_sc;
				else if (b < 8'h20) set_err(code);
				else if (b == "\\") sc = base + STR_ESC;
			end
			STR_ESC: begin
				if (b inside {"\"", "\\", "/", "b", "f", "n", "r", "t"}) sc = base + STR_BODY;
				else if (b == "u") begin sc = base + STR_HEX; hexcnt = 0; hexacc = '0; end
				else set_err(code);
			end
			STR_HEX: begin
				if (h > 15) begin
					set_err(code);
				end else begin
					hexacc = {hexacc[11:0], 4'(h)};
					hexcnt++;
					if (hexcnt == 4) begin
						hexcnt = 0;
						if (hisur) begin
							hisur = 1'b0;
							if (hexacc < 16'hDC00 || hexacc > 16'hDFFF) set_err(code);
							else sc = base + STR_BODY;
						end else if (hexacc >= 16'hD800 && hexacc <= 16'hDBFF) begin
							hisur = 1'b1;
							sc = base + STR_BSLASH;
						end else if (hexacc >= 16'hDC00 && hexacc <= 16'hDFFF) begin
							set_err(code);
						end else begin
							sc = base + STR_BODY;
						end
					end
				end
			end
			STR_BSLASH: begin
				if (b == "\\") sc = base + STR_U;
				else set_err(code);
			end
			default: begin
				if (b == "u") begin sc = base + STR_HEX; hexcnt = 0; hexacc = '0; end
				else set_err(code);
			end
		endcase
	endtask

	task automatic scan_byte(logic [7:0] b);
		int unsigned k, s;
		s = sc;
		if (s >= SC_VAL_STR) begin
			string_step(SC_VAL_STR, b, STS_STRING, SC_AFTER);
		end else if (s >= SC_KEY_STR) begin
			string_step(SC_KEY_STR, b, STS_KEY, SC_COLON);
		end else if (s >= SC_LIT && s < SC_NUM_SIGN) begin
			k = s - SC_LIT;
			if (litpos >= ((k == 1) ? 5 : 4) || b != lit_char(k, litpos)) begin
				set_err(STS_LITERAL);
			end else begin
				litpos++;
				if (litpos == ((k == 1) ? 5 : 4)) begin litpos = 0; sc = SC_AFTER; end
			end
		end else begin
			case (s)
				SC_TOP: if (!is_ws(b)) begin
					if (b == "{") open_lvl(1'b1); else set_err(STS_NOT_OBJ);
				end
				SC_OBJ_FIRST: if (!is_ws(b)) begin
					if (b == "}") close_lvl();
					else if (b == "\"") sc = SC_KEY_STR + STR_BODY;
					else set_err(STS_KEY);
				end
				SC_OBJ_KEY: if (!is_ws(b)) begin
					if (b == "\"") sc = SC_KEY_STR + STR_BODY; else set_err(STS_KEY);
				end
				SC_COLON: if (!is_ws(b)) begin
					if (b == ":") sc = SC_VALUE; else set_err(STS_COLON);
				end
				SC_VALUE: if (!is_ws(b)) start_value(b);
				SC_ARR_FIRST: if (!is_ws(b)) begin
					if (b == "]") close_lvl(); else start_value(b);
				end
				SC_AFTER: finish_value(b);
				SC_DONE: if (!is_ws(b)) set_err(STS_TRAILING);
				SC_NUM_SIGN: begin
					if (b == "0") sc = SC_NUM_ZERO;
					else if (b >= "1" && b <= "9") sc = SC_NUM_INT;
					else set_err(STS_NUMBER);
				end
				SC_NUM_ZERO, SC_NUM_INT: begin
					if (is_dig(b)) begin
						if (s == SC_NUM_ZERO) set_err(STS_NUMBER);
					end
					else if (b == ".") sc = SC_NUM_DOT;
					else if (b == "e" || b == "E") sc = SC_NUM_EXP;
					else finish_value(b);
				end
				SC_NUM_DOT: if (is_dig(b)) sc = SC_NUM_FRAC; else set_err(STS_NUMBER);
				SC_NUM_FRAC: if (!is_dig(b)) begin
					if (b == "e" || b == "E") sc = SC_NUM_EXP; else finish_value(b);
				end
				SC_NUM_EXP: begin
					if (b == "+" || b == "-") sc = SC_NUM_EXPSIGN;
					else if (is_dig(b)) sc = SC_NUM_EXPDIG;
					else set_err(STS_NUMBER);
				end
				SC_NUM_EXPSIGN: if (is_dig(b)) sc = SC_NUM_EXPDIG; else set_err(STS_NUMBER);
				SC_NUM_EXPDIG: if (!is_dig(b)) finish_value(b);
				default: set_err(STS_NOT_OBJ);
			endcase
		end
	endtask

	// Verdict on the final byte when no error is pending.
	function automatic status_t end_status();
		if (sc >= SC_VAL_STR) return STS_STRING;
		if (sc >= SC_KEY_STR) return STS_KEY;
		if (sc >= SC_LIT && sc < SC_NUM_SIGN) return STS_LITERAL;
		case (sc)
			SC_DONE: return STS_OK;
			SC_OBJ_FIRST, SC_OBJ_KEY, SC_ARR_FIRST: return STS_UNTERM;
			SC_COLON: return STS_COLON;
			SC_VALUE: return top_obj() ? STS_VALUE : STS_UNTERM;
			SC_AFTER, SC_NUM_ZERO, SC_NUM_INT, SC_NUM_FRAC, SC_NUM_EXPDIG: return STS_COMMA;
			SC_NUM_SIGN, SC_NUM_DOT, SC_NUM_EXP, SC_NUM_EXPSIGN: return STS_NUMBER;
			default: return STS_NOT_OBJ;
		endcase
	endfunction

	task automatic predict_byte(logic [7:0] b, logic last);
		verdict_t v;
		if (sc_err == STS_RUN) scan_byte(b);
		v.sts = sc_err;
		if (last && v.sts == STS_RUN) v.sts = end_status();
		v.lvl = 9'(lvl);
		verdict_q.insert(verdict_q.size(), v);
		if (last) begin
			if (v.sts == STS_OK) n_ok++; else n_err++;
			clear_scan();
		end
	endtask

	// Byte request driver: bursts of random length separated by random gaps.
	int         burst_left = 0, gap_left = 0;
	logic       drv_go;
	text_byte_t drv_item;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'd0;
			last_byte <= 1'b0;
		end else begin
			drv_go = in_valid;
			if (in_valid && in_ready) begin
				predict_byte(data_byte, last_byte);
				drv_go = 1'b0;
			end
			if (!drv_go) begin
				if (gap_left > 0 && !steady) begin
					gap_left--;
				end else if (!hold && pend_q.size() > 0) begin
					drv_item = pend_q.pop_front();
					data_byte <= drv_item.b;
					last_byte <= drv_item.last;
					drv_go = 1'b1;
					if (!steady) begin
						if (burst_left == 0) burst_left = $urandom_range(1, 24);
						burst_left--;
						if (burst_left == 0) gap_left = $urandom_range(0, 6);
					end
				end
			end
			in_valid <= drv_go;
		end
	end

	// Result monitor; the stall pattern changes with bits 9:8 of the cycle counter.
	int       mon_cyc = 0;
	verdict_t mon_exp;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (verdict_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("ERROR: result with nothing expected: status %0d level %0d",
							status, nest_level);
				end else begin
					mon_exp = verdict_q.pop_front();
					if (status !== mon_exp.sts || nest_level !== mon_exp.lvl) begin
						n_fail++;
						if (n_fail <= 10)
							$display("ERROR: status %0d level %0d, expected %s level %0d",
								status, nest_level, mon_exp.sts.name(), mon_exp.lvl);
					end
				end
			end
			mon_cyc++;
			case (mon_cyc[9:8])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= ($urandom_range(0, 3) != 0);
				2'd2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (mon_cyc % 3 != 0);
			endcase
		end
	end

	// Append one byte to the document buffer.
	task automatic add_byte(logic [7:0] c);
		doc.insert(doc.size(), c);
	endtask

	// Text generation into the document buffer.
	task automatic put(string s);
		foreach (s[i]) add_byte(s[i]);
	endtask

	task automatic put_ws();
		int n;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: add_byte(" ");
				1: add_byte(8'h09);
				2: add_byte(8'h0A);
				default: add_byte(8'h0D);
			endcase
		end
	endtask

	function automatic logic [7:0] hex_ch(logic [3:0] v);
		if (v < 10) return "0" + v;
		return ($urandom_range(0, 1) ? "a" : "A") + v - 10;
	endfunction

	task automatic put_hex4(logic [15:0] v);
		put("\\u");
		for (int i = 3; i >= 0; i--) add_byte(hex_ch(v[i*4 +: 4]));
	endtask

	task automatic put_string();
		int         n;
		logic [7:0] c;
		string      esc;
		esc = "\"\\/bfnrt";
		n = $urandom_range(0, 6);
		add_byte("\"");
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: begin add_byte("\\"); add_byte(esc[$urandom_range(0, 7)]); end
				1: put_hex4(16'($urandom_range(0, 16'hD7FF)));
				2: begin
					put_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
					put_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)));
				end
				3: add_byte(8'($urandom_range(8'h80, 8'hFF)));
				default: begin
					c = 8'($urandom_range(8'h20, 8'h7E));
					if (c == "\"" || c == "\\") c = "a";
					add_byte(c);
				end
			endcase
		end
		add_byte("\"");
	endtask

	task automatic put_number();
		if ($urandom_range(0, 2) == 0) add_byte("-");
		if ($urandom_range(0, 3) == 0) begin
			add_byte("0");
		end else begin
			add_byte(8'($urandom_range("1", "9")));
			repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range("0", "9")));
		end
		if ($urandom_range(0, 2) == 0) begin
			add_byte(".");
			repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range("0", "9")));
		end
		if ($urandom_range(0, 3) == 0) begin
			add_byte($urandom_range(0, 1) ? "e" : "E");
			case ($urandom_range(0, 2))
				0: add_byte("+");
				1: add_byte("-");
				default: ;
			endcase
			repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range("0", "9")));
		end
	endtask

	task automatic put_value(int depth);
		int r;
		r = $urandom_range(0, 9);
		if (depth < 4 && r < 2) put_object(depth + 1);
		else if (depth < 4 && r < 4) begin
			add_byte("[");
			put_ws();
			if ($urandom_range(0, 4) != 0) begin
				repeat ($urandom_range(1, 3)) begin
					put_value(depth + 1);
					put_ws();
					add_byte(",");
					put_ws();
				end
				void'(doc.pop_back());
				put_ws();
			end
			add_byte("]");
		end
		else if (r < 6) put_string();
		else if (r < 8) put_number();
		else if (r == 8) put($urandom_range(0, 1) ? "true" : "false");
		else put("null");
	endtask

	task automatic put_object(int depth);
		add_byte("{");
		put_ws();
		if ($urandom_range(0, 4) != 0) begin
			repeat ($urandom_range(1, 3)) begin
				put_string();
				put_ws();
				add_byte(":");
				put_ws();
				put_value(depth);
				put_ws();
				add_byte(",");
				put_ws();
			end
			void'(doc.pop_back());
			put_ws();
		end
		add_byte("}");
	endtask

	// Hand the buffered document to the driver, marking its final byte.
	task automatic send_doc();
		text_byte_t t;
		foreach (doc[i]) begin
			t.b = doc[i];
			t.last = (i == doc.size() - 1);
			pend_q.insert(pend_q.size(), t);
		end
		n_bytes += doc.size();
		if (doc.size() > 0) n_docs++;
		doc.delete();
	endtask

	task automatic send_text(string s);
		put(s);
		send_doc();
	endtask

	// One random document: mostly well formed, some damaged, some pure noise.
	task automatic send_random_doc();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
		end else begin
			put_ws();
			put_object(0);
			put_ws();
			case (r)
				1, 2: doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
				3: doc = doc[0 : $urandom_range(0, doc.size() - 1)];
				4: doc.insert($urandom_range(0, doc.size() - 1), 8'($urandom_range(0, 255)));
				default: ;
			endcase
		end
		send_doc();
	endtask

	task automatic send_nested(int n, bit closed);
		put("{\"d\":");
		repeat (n) add_byte("[");
		if (closed) begin
			add_byte("1");
			repeat (n) add_byte("]");
			add_byte("}");
		end
		send_doc();
	endtask

	task automatic wait_idle();
		while (pend_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		max_nesting <= v;
		do @(posedge clk); while (!cfg_ready);
		lim = v;
		cfg_valid <= 1'b0;
	endtask

	// Main sequence: reset, directed documents, then random phases per limit.
	logic [7:0] limits[5];
	int         rnd_bytes;
	initial begin
		limits = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd0};
		limits[4] = 8'($urandom_range(2, 40));
		clear_scan();
		lim = MaxNestingRst;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		steady = 1'b1;
		send_text("{}");
		send_text("[]");
		send_text("{\"a\":01}");
		send_text("{\"k\":tru");
		send_text("{\"\\uDC00\"");
		send_text("{\"v\":\"\t\"}");
		send_text("{} x");
		send_text("{\"a\" 1");
		send_text("{\"a\":-");
		wait_idle();
		steady = 1'b0;
		rnd_bytes = 0;
		foreach (limits[p]) begin
			write_limit(limits[p]);
			if (limits[p] == 8'd255) begin
				send_nested(256, 1'b0);
			end else begin
				send_nested(limits[p], 1'b1);
				send_nested(limits[p] + 1, 1'b1);
			end
			while (rnd_bytes < 40 * (p + 1)) begin
				rnd_bytes -= n_bytes;
				send_random_doc();
				rnd_bytes += n_bytes;
				if (p == 2 && rnd_bytes > 100 && !hold) begin
					// Hold the sender until every outstanding result has drained.
					hold = 1'b1;
					while (verdict_q.size() != 0 || in_valid) @(posedge clk);
					repeat ($urandom_range(3, 20)) @(posedge clk);
					hold = 1'b0;
				end
			end
			steady = (p == 3);
			wait_idle();
		end
		repeat (20) @(posedge clk);
		$display("Checked %0d documents (%0d bytes, %0d results): %0d accepted, %0d rejected.",
			n_docs, n_bytes, n_results, n_ok, n_err);
		$display("Nesting limits 128, 0, 1, 255, 3 and a random one were exercised.");
		if (n_fail == 0 && verdict_q.size() == 0) begin
			$display("tb_strict_json_object_validator: PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", n_fail, verdict_q.size());
			$display("tb_strict_json_object_validator: FAIL");
		end
		$finish;
	end

	// Overall time limit.
	initial begin
		#5000000;
		$display("Timed out with %0d results still expected", verdict_q.size());
		$display("tb_strict_json_object_validator: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
design/sjv_pkg.sv
design/sjv_front.sv
design/sjv_queue.sv
design/sjv_back.sv
design/strict_json_object_validator.sv
dv/tb_strict_json_object_validator.sv
